// File: hdl/simpint_pkg.sv
`default_nettype none

package simpint_pkg;

    localparam int GRID_MAX_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int SMP_W     = 32;
    localparam int SUM_W     = 56;
    localparam int MAG_ACC_W = 57;
    localparam int GRID_W    = 11;
    localparam int IDX_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_VAL_W = 11;
    localparam int Q_DEPTH   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_FIRST = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_FINAL = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_COL_FIRST = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_COL_FINAL = CFG_IDX_W'(4);

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_BAD_REGION     = 2'd1,
        ST_COUNT_MISMATCH = 2'd2
    } t_status;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } t_cfg;

    typedef struct packed {
        logic signed [SMP_W-1:0] real_part;
        logic signed [SMP_W-1:0] imag_part;
        logic                    last_sample;
    } t_sample;

    // weight is nz ? (1 << sh) : 0
    typedef struct packed {
        logic       nz;
        logic [2:0] sh;
    } t_weight;

    typedef struct packed {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
        t_weight                 wt;
        logic                    last;
        t_status                 status;
    } t_qent;

    typedef struct packed {
        logic signed [SUM_W-1:0] real_total;
        logic signed [SUM_W-1:0] imag_total;
        logic [SUM_W-1:0]        sum_magnitude;
        t_status                 status;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/simpint_chan.sv
`default_nettype none

interface simpint_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/simpint_front.sv
`default_nettype none

module simpint_front #(
    parameter int GRID_MAX    = simpint_pkg::GRID_MAX_DEF,
    parameter int SAMPLE_BITS = simpint_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    simpint_chan.sink   i_cfg,
    simpint_chan.sink   i_smp,
    simpint_chan.source o_ent
);
    import simpint_pkg::*;

    localparam int CW = ($clog2(GRID_MAX + 1) > GRID_W) ? $clog2(GRID_MAX + 1) : GRID_W;
    localparam logic [CW-1:0] GRID_LIMIT = CW'(GRID_MAX);

    logic [GRID_W-1:0] r_grid_size;
    logic [IDX_W-1:0]  r_row_first;
    logic [IDX_W-1:0]  r_row_final;
    logic [IDX_W-1:0]  r_col_first;
    logic [IDX_W-1:0]  r_col_final;
    logic [CW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic              r_overrun;

    logic [CW-1:0]     grid;
    logic [CW-1:0]     grid_m1;
    logic [CW-1:0]     row_upper;
    logic [CW-1:0]     col_upper;
    logic              bad;
    logic              at_end;
    t_weight           wr;
    t_weight           wc;
    t_weight           wt;
    t_status           status;
    logic              accept;
    logic [CW:0]       col_inc;
    logic [CW:0]       row_inc;

    function automatic logic [CW-1:0] upper_of(logic [IDX_W-1:0] first,
                                               logic [IDX_W-1:0] fin);
        logic [IDX_W-1:0] diff;
        diff = fin - first;
        if (fin > first && diff[0]) begin
            return CW'(fin) + CW'(1);
        end
        return CW'(fin);
    endfunction

    // axis weight 1, 2 or 4 as a shift; zero outside the span
    function automatic t_weight axis_wt(logic [CW-1:0] idx, logic [IDX_W-1:0] first,
                                        logic [CW-1:0] upper);
        t_weight       w;
        logic [CW-1:0] k;
        k = idx - CW'(first);
        w = '0;
        if (idx < CW'(first) || idx > upper) begin
            w = '0;
        end else if (k == '0 || idx == upper) begin
            w.nz = 1'b1;
            w.sh = 3'd0;
        end else if (k[0]) begin
            w.nz = 1'b1;
            w.sh = 3'd2;
        end else begin
            w.nz = 1'b1;
            w.sh = 3'd1;
        end
        return w;
    endfunction

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_W'(1);
            r_row_first <= '0;
            r_row_final <= '0;
            r_col_first <= '0;
            r_col_final <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_GRID_SIZE: r_grid_size <= i_cfg.data.value[GRID_W-1:0];
                CFG_ROW_FIRST: r_row_first <= i_cfg.data.value[IDX_W-1:0];
                CFG_ROW_FINAL: r_row_final <= i_cfg.data.value[IDX_W-1:0];
                CFG_COL_FIRST: r_col_first <= i_cfg.data.value[IDX_W-1:0];
                CFG_COL_FINAL: r_col_final <= i_cfg.data.value[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        grid      = CW'(r_grid_size);
        grid_m1   = grid - CW'(1);
        row_upper = upper_of(r_row_first, r_row_final);
        col_upper = upper_of(r_col_first, r_col_final);
        bad       = (grid == '0) || (grid > GRID_LIMIT)
                 || (r_row_final <= r_row_first) || (r_col_final <= r_col_first)
                 || (row_upper >= grid) || (col_upper >= grid);
        at_end    = !r_overrun && (grid != '0) && (r_row == grid_m1) && (r_col == grid_m1);
        wr        = axis_wt(r_row, r_row_first, row_upper);
        wc        = axis_wt(r_col, r_col_first, col_upper);
        wt.nz     = !r_overrun && !bad && wr.nz && wc.nz;
        wt.sh     = wr.sh + wc.sh;
        if (bad) begin
            status = ST_BAD_REGION;
        end else if (at_end) begin
            status = ST_OK;
        end else begin
            status = ST_COUNT_MISMATCH;
        end
        col_inc = {1'b0, r_col} + (CW+1)'(1);
        row_inc = {1'b0, r_row} + (CW+1)'(1);
    end

    assign accept      = i_smp.valid && o_ent.ready;
    assign i_smp.ready = o_ent.ready;
    assign o_ent.valid = i_smp.valid;

    always_comb begin
        o_ent.data.re     = SMP_W'(signed'(i_smp.data.real_part[SAMPLE_BITS-1:0]));
        o_ent.data.im     = SMP_W'(signed'(i_smp.data.imag_part[SAMPLE_BITS-1:0]));
        o_ent.data.wt     = wt;
        o_ent.data.last   = i_smp.data.last_sample;
        o_ent.data.status = status;
    end

    // grid position of the next sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_overrun <= 1'b0;
        end else if (accept) begin
            if (i_smp.data.last_sample) begin
                r_row     <= '0;
                r_col     <= '0;
                r_overrun <= 1'b0;
            end else if (col_inc >= {1'b0, grid}) begin
                r_col <= '0;
                if (row_inc >= {1'b0, grid}) begin
                    r_row     <= '0;
                    r_overrun <= 1'b1;
                end else begin
                    r_row <= row_inc[CW-1:0];
                end
            end else begin
                r_col <= col_inc[CW-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/simpint_queue.sv
`default_nettype none

module simpint_queue (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    simpint_chan.sink   i_in,
    simpint_chan.source o_out
);
    import simpint_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int NW = $clog2(Q_DEPTH + 1);

    t_qent         r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_count;
    logic          push;
    logic          pop;

    assign i_in.ready  = (r_count != NW'(Q_DEPTH));
    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_mem[r_rd];
    assign push        = i_in.valid && i_in.ready;
    assign pop         = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + NW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/simpint_isqrt.sv
`default_nettype none

module simpint_isqrt #(
    parameter int N = simpint_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [2*N-1:0] i_rad,
    output logic              o_done,
    output logic [N-1:0]      o_root
);
    localparam int KW = $clog2(N);

    logic [2*N-1:0] r_rad;
    logic [N+1:0]   r_rem;
    logic [N-1:0]   r_root;
    logic [KW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [N+3:0]   shifted;
    logic [N+3:0]   trial;
    logic [N+3:0]   diff;
    logic           ge;
    logic [N+1:0]   n_rem;

    // one root bit per cycle, msb first
    always_comb begin
        shifted = {r_rem, r_rad[2*N-1 -: 2]};
        trial   = {2'b00, r_root, 2'b01};
        diff    = shifted - trial;
        ge      = (shifted >= trial);
        n_rem   = ge ? diff[N+1:0] : shifted[N+1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= KW'(N - 1);
        end else if (r_busy) begin
            r_rad  <= {r_rad[2*N-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= {r_root[N-2:0], ge};
            r_cnt  <= r_cnt - KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: hdl/simpint_back.sv
`default_nettype none

module simpint_back #(
    parameter int SAMPLE_BITS = simpint_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    simpint_chan.sink   i_ent,
    simpint_chan.source o_res
);
    import simpint_pkg::*;

    localparam int N = SAMPLE_BITS;

    typedef enum logic [5:0] {
        B_IDLE   = 6'b000001,
        B_SQUARE = 6'b000010,
        B_START  = 6'b000100,
        B_ROOT   = 6'b001000,
        B_ACC    = 6'b010000,
        B_EMIT   = 6'b100000
    } t_bstate;

    t_bstate                 r_state;
    t_bstate                 n_state;
    t_qent                   r_ent;
    logic [2*N-1:0]          r_sq_re;
    logic [2*N-1:0]          r_sq_im;
    logic signed [SUM_W-1:0] r_acc_re;
    logic signed [SUM_W-1:0] r_acc_im;
    logic [MAG_ACC_W-1:0]    r_acc_mag;
    logic                    r_out_valid;
    t_result                 r_out;

    logic signed [N-1:0]     s_re;
    logic signed [N-1:0]     s_im;
    logic signed [2*N-1:0]   prod_re;
    logic signed [2*N-1:0]   prod_im;
    logic [2*N-1:0]          radicand;
    logic                    root_done;
    logic [N-1:0]            root;
    logic                    pop;
    logic                    out_free;
    logic signed [SUM_W-1:0] add_re;
    logic signed [SUM_W-1:0] add_im;
    logic [MAG_ACC_W-1:0]    add_mag;

    assign i_ent.ready = (r_state == B_IDLE);
    assign pop         = i_ent.valid && (r_state == B_IDLE);
    assign out_free    = !r_out_valid || o_res.ready;

    always_comb begin
        s_re     = r_ent.re[N-1:0];
        s_im     = r_ent.im[N-1:0];
        prod_re  = s_re * s_re;
        prod_im  = s_im * s_im;
        radicand = r_sq_re + r_sq_im;
        add_re   = SUM_W'(r_ent.re) <<< r_ent.wt.sh;
        add_im   = SUM_W'(r_ent.im) <<< r_ent.wt.sh;
        add_mag  = MAG_ACC_W'(root) << r_ent.wt.sh;
    end

    simpint_isqrt #(
        .N (N)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == B_START),
        .i_rad   (radicand),
        .o_done  (root_done),
        .o_root  (root)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_ent.valid) begin
                    if (i_ent.data.wt.nz) begin
                        n_state = B_SQUARE;
                    end else if (i_ent.data.last) begin
                        n_state = B_EMIT;
                    end
                end
            end
            B_SQUARE: n_state = B_START;
            B_START:  n_state = B_ROOT;
            B_ROOT: begin
                if (root_done) begin
                    n_state = B_ACC;
                end
            end
            B_ACC:    n_state = r_ent.last ? B_EMIT : B_IDLE;
            B_EMIT: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default:  n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ent <= i_ent.data;
        end
        if (r_state == B_SQUARE) begin
            r_sq_re <= unsigned'(prod_re);
            r_sq_im <= unsigned'(prod_im);
        end
        if (r_state == B_EMIT && out_free) begin
            if (r_ent.status == ST_OK) begin
                r_out.real_total    <= r_acc_re;
                r_out.imag_total    <= r_acc_im;
                r_out.sum_magnitude <= r_acc_mag[MAG_ACC_W-1] ? '1 : r_acc_mag[SUM_W-1:0];
            end else begin
                r_out.real_total    <= '0;
                r_out.imag_total    <= '0;
                r_out.sum_magnitude <= '0;
            end
            r_out.status <= r_ent.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_acc_re    <= '0;
            r_acc_im    <= '0;
            r_acc_mag   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_ACC) begin
                r_acc_re  <= r_acc_re + add_re;
                r_acc_im  <= r_acc_im + add_im;
                r_acc_mag <= r_acc_mag + add_mag;
            end
            if (r_state == B_EMIT && out_free) begin
                r_acc_re    <= '0;
                r_acc_im    <= '0;
                r_acc_mag   <= '0;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

`default_nettype wire

// File: hdl/simpson_2d_region_integrator.sv
// result: with queue and back end idle, a last sample of nonzero weight goes through the
// square, start, root and accumulate states before emit registers the result; one of zero
// weight goes from idle to emit. back end: one sample at a time; pop, square, start,
// one root bit per cycle, done, accumulate if weight is nonzero, else pop alone;
// the 4-entry queue takes a sample per cycle until full
// reset: synchronous, active low; registers return to reset values, sums and position clear
`default_nettype none

module simpson_2d_region_integrator #(
    parameter int GRID_MAX    = simpint_pkg::GRID_MAX_DEF,
    parameter int SAMPLE_BITS = simpint_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    simpint_chan.sink   i_cfg,
    simpint_chan.sink   i_smp,
    simpint_chan.source o_res
);
    import simpint_pkg::*;

    simpint_chan #(.T(t_qent)) u_fq ();
    simpint_chan #(.T(t_qent)) u_qb ();

    simpint_front #(
        .GRID_MAX    (GRID_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_smp   (i_smp),
        .o_ent   (u_fq.source)
    );

    simpint_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_fq.sink),
        .o_out   (u_qb.source)
    );

    simpint_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ent   (u_qb.sink),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
